### src/mqfe_pkg.sv
// Shared constants, state encoding and helper functions for the MRU queue fetch engine.
package mqfe_pkg;

    // Queue sizing
    localparam int MAX_SIZE    = 2048;
    localparam int EXTRA_SLOTS = 2048;
    localparam int SLOT_COUNT  = MAX_SIZE + EXTRA_SLOTS;
    localparam int RESET_SIZE  = (MAX_SIZE < 2048) ? MAX_SIZE : 2048;

    // Widths: slot numbers run 1..SLOT_COUNT, memory addresses 0..SLOT_COUNT-1
    localparam int FIELD_W = 12;
    localparam int ADDR_W  = $clog2(SLOT_COUNT);
    localparam int SLOT_W  = $clog2(SLOT_COUNT + 1);
    localparam int TREE_W  = SLOT_W;

    // First descent step: highest power of two not above SLOT_COUNT
    localparam logic [SLOT_W-1:0] STEP_TOP = SLOT_W'(1) << (SLOT_W - 1);

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DESC_RD,
        ST_DESC_CMP,
        ST_FETCH,
        ST_MOVE,
        ST_CLEAR,
        ST_TREE_DEC,
        ST_TREE_INC,
        ST_DONE
    } mqfe_state_t;

    // Lowest set bit of a walker slot number
    function automatic logic [SLOT_W:0] low_bit(input logic [SLOT_W:0] x);
        return x & (~x + 1'b1);
    endfunction

    // Fenwick count of node i when slots 1..n are occupied:
    // the number of occupied slots in (i - lowbit(i), i]
    function automatic logic [TREE_W-1:0] sweep_tree(input logic [SLOT_W-1:0] i,
                                                     input logic [FIELD_W-1:0] n);
        logic [SLOT_W-1:0] lb;
        logic [SLOT_W-1:0] low;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] span;
        lb  = i & (~i + 1'b1);
        low = i - lb;
        nx  = SLOT_W'(n);
        if (nx <= low)
        begin
            return '0;
        end
        span = nx - low;
        return TREE_W'((span > lb) ? lb : span);
    endfunction

endpackage

### src/mqfe_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module mqfe_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, returns old data on a same-cycle collision
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/mru_queue_fetch_engine_top.sv
// Top level of the MRU queue fetch engine: control sequencer, slot store and Fenwick tree.
// An in-range request runs a 13-step tree descent, then a slot move through fetch, move and clear
// states, then two pipelined Fenwick tree walks (decrement, then increment) before its result
// posts; a refused request goes straight to posting. One request is in flight at a time and the
// next can be accepted in the same cycle as a result posts; a stalled result holds the engine
// until the output is free. Reset, and every size write, starts a sweep that rewrites all 4096
// entries of both memories; no request is accepted during it. The size register resets to 2048.
module mru_queue_fetch_engine_top
    import mqfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] initial_size,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] value,
    output logic               error
);

    mqfe_state_t state_reg, state_next;

    logic [FIELD_W-1:0] size_reg;
    logic [SLOT_W-1:0]  tail_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    logic [SLOT_W-1:0]  pos_reg;
    logic [FIELD_W-1:0] rem_reg;
    logic [SLOT_W-1:0]  step_reg;
    logic [SLOT_W:0]    cur_reg;
    logic               pend_valid_reg;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic [FIELD_W-1:0] res_value_reg;
    logic               res_error_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] value_reg;
    logic               error_reg;

    // Memory ports
    logic               tree_we;
    logic [ADDR_W-1:0]  tree_waddr;
    logic [TREE_W-1:0]  tree_wdata;
    logic [ADDR_W-1:0]  tree_raddr;
    logic [TREE_W-1:0]  tree_rdata;
    logic               val_we;
    logic [ADDR_W-1:0]  val_waddr;
    logic [FIELD_W-1:0] val_wdata;
    logic [ADDR_W-1:0]  val_raddr;
    logic [FIELD_W-1:0] val_rdata;

    // Shared combinational terms
    logic               cfg_fire;
    logic               in_fire;
    logic               out_free;
    logic               req_err;
    logic [FIELD_W-1:0] size_sat;
    logic [SLOT_W:0]    desc_next;
    logic               desc_ok;
    logic [ADDR_W-1:0]  desc_addr;
    logic [SLOT_W-1:0]  step_shift;
    logic               take;
    logic               cur_live;
    logic [ADDR_W-1:0]  cur_addr;
    logic [SLOT_W:0]    cur_step;
    logic               walk_done;
    logic [SLOT_W-1:0]  sweep_slot;

    // Hold requests off while a size write is offered, since it restarts the sweep
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_fire   = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign size_sat = (initial_size > FIELD_W'(MAX_SIZE)) ? FIELD_W'(MAX_SIZE) : initial_size;
    assign req_err  = (position == '0) || (position > size_reg)
                   || (tail_reg >= SLOT_W'(SLOT_COUNT));

    // Descent probe: slot pos + step, address one below
    assign desc_next  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign desc_ok    = desc_next <= (SLOT_W + 1)'(SLOT_COUNT);
    assign desc_addr  = ADDR_W'(desc_next - 1'b1);
    assign step_shift = step_reg >> 1;
    assign take       = tree_rdata < TREE_W'(rem_reg);

    // Tree update walker
    assign cur_live  = cur_reg <= (SLOT_W + 1)'(SLOT_COUNT);
    assign cur_addr  = ADDR_W'(cur_reg - 1'b1);
    assign cur_step  = cur_reg + low_bit(cur_reg);
    assign walk_done = !cur_live && !pend_valid_reg;

    assign sweep_slot = SLOT_W'(sweep_reg) + 1'b1;

    mqfe_ram #(
        .WIDTH (TREE_W),
        .DEPTH (SLOT_COUNT)
    ) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    mqfe_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == ADDR_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = req_err ? ST_DONE : ST_DESC_RD;
                end
            end
            ST_DESC_RD:
            begin
                if (desc_ok)
                begin
                    state_next = ST_DESC_CMP;
                end
                else if (step_shift == '0)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_DESC_CMP:  state_next = (step_shift == '0) ? ST_FETCH : ST_DESC_RD;
            ST_FETCH:     state_next = ST_MOVE;
            ST_MOVE:      state_next = ST_CLEAR;
            ST_CLEAR:     state_next = ST_TREE_DEC;
            ST_TREE_DEC:
            begin
                if (walk_done)
                begin
                    state_next = ST_TREE_INC;
                end
            end
            ST_TREE_INC:
            begin
                if (walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_SWEEP;
        endcase
        // A size write restarts the reload sweep
        if (cfg_fire)
        begin
            state_next = ST_SWEEP;
        end
    end

    // Memory port controls
    always_comb
    begin
        tree_we    = 1'b0;
        tree_waddr = pend_addr_reg;
        tree_wdata = tree_rdata + 1'b1;
        tree_raddr = desc_addr;
        val_we     = 1'b0;
        val_waddr  = pos_reg[ADDR_W-1:0];
        val_wdata  = '0;
        val_raddr  = pos_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_SWEEP:
            begin
                tree_we    = 1'b1;
                tree_waddr = sweep_reg;
                tree_wdata = sweep_tree(sweep_slot, size_reg);
                val_we     = 1'b1;
                val_waddr  = sweep_reg;
                val_wdata  = (sweep_slot <= SLOT_W'(size_reg)) ? FIELD_W'(sweep_slot) : '0;
            end
            ST_MOVE:
            begin
                // new tail slot is tail + 1, address tail
                val_we    = 1'b1;
                val_waddr = tail_reg[ADDR_W-1:0];
                val_wdata = val_rdata;
            end
            ST_CLEAR:
            begin
                val_we = 1'b1;
            end
            ST_TREE_DEC:
            begin
                tree_we    = pend_valid_reg;
                tree_wdata = tree_rdata - 1'b1;
                tree_raddr = cur_addr;
            end
            ST_TREE_INC:
            begin
                tree_we    = pend_valid_reg;
                tree_raddr = cur_addr;
            end
            default:
            begin
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= FIELD_W'(RESET_SIZE);
            tail_reg       <= SLOT_W'(RESET_SIZE);
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Load a new size and restart the sweep, or advance the sweep and the tail
            if (cfg_fire)
            begin
                size_reg  <= size_sat;
                tail_reg  <= SLOT_W'(size_sat);
                sweep_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_SWEEP)
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
                if (state_reg == ST_MOVE)
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            // Track the read in flight for the tree walker
            if (state_reg == ST_TREE_DEC || state_reg == ST_TREE_INC)
            begin
                pend_valid_reg <= cur_live;
            end
            else
            begin
                pend_valid_reg <= 1'b0;
            end
            // Post or drop the result transaction
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rem_reg       <= position;
                pos_reg       <= '0;
                step_reg      <= STEP_TOP;
                res_value_reg <= '0;
                res_error_reg <= 1'b1;
            end
            ST_DESC_RD:
            begin
                if (!desc_ok)
                begin
                    step_reg <= step_shift;
                end
            end
            ST_DESC_CMP:
            begin
                if (take)
                begin
                    pos_reg <= desc_next[SLOT_W-1:0];
                    rem_reg <= rem_reg - FIELD_W'(tree_rdata);
                end
                step_reg <= step_shift;
            end
            ST_MOVE:
            begin
                res_value_reg <= val_rdata;
                res_error_reg <= 1'b0;
            end
            ST_CLEAR:
            begin
                // source slot is pos + 1
                cur_reg <= {1'b0, pos_reg} + 1'b1;
            end
            ST_TREE_DEC, ST_TREE_INC:
            begin
                if (cur_live)
                begin
                    pend_addr_reg <= cur_addr;
                    cur_reg       <= cur_step;
                end
                else if (walk_done)
                begin
                    cur_reg <= {1'b0, tail_reg};
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_DONE && out_free)
        begin
            value_reg <= res_value_reg;
            error_reg <= res_error_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign error     = error_reg;

endmodule

### src/mqfe_checker.sv
// Port-level checker for the MRU queue fetch engine, bound to the top level.
module mqfe_checker
    import mqfe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [FIELD_W-1:0] initial_size,
    input logic               in_valid,
    input logic               in_ready,
    input logic [FIELD_W-1:0] position,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] value,
    input logic               error
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(error))
    else $error("result changed while stalled");

    // A refused request returns zero, a served one never does
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> value == '0)
    else $error("error result carries a nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> value != '0)
    else $error("served request returned zero");

    // One request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

    // A size write starts the reload, which blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
    else $error("request port open right after a size write");

endmodule

bind mru_queue_fetch_engine_top mqfe_checker u_mqfe_checker (.*);
